/* sv/b64d_pkg.sv */
// Shared types, constants and the character lookup of the base64 decoder.
`default_nettype none

package b64d_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned SEXTET_W  = 6;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TOTAL_W   = 16;
  localparam int unsigned CAP_W     = 16;
  localparam int unsigned CODE_W    = 7;
  localparam int unsigned MAX_RES   = 4;
  localparam int unsigned RES_CNT_W = 3;
  localparam int unsigned GROUP_LEN = 3;

  // Lookup codes beyond the 64 sextet values.
  localparam logic [CODE_W-1:0] PAD_CODE = 7'd64;
  localparam logic [CODE_W-1:0] BAD_CODE = 7'd127;

  // Configuration register indexes (byte address is four times the index).
  localparam logic REG_OUTPUT_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    kind_e              kind;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } result_t;

  // All results caused by one input item, in delivery order.
  typedef struct packed {
    result_t [MAX_RES-1:0]  entry;
    logic [RES_CNT_W-1:0]   count;
  } bundle_t;

  // Maps a character to its sextet value, PAD_CODE for '=' or BAD_CODE.
  function automatic logic [CODE_W-1:0] char_code(input logic [CHAR_W-1:0] c);
    logic [CODE_W-1:0] code;
    if (c >= 8'h41 && c <= 8'h5A) begin
      code = CODE_W'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      code = CODE_W'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      code = CODE_W'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      code = 7'd62;
    end else if (c == 8'h2F) begin
      code = 7'd63;
    end else if (c == 8'h3D) begin
      code = PAD_CODE;
    end else begin
      code = BAD_CODE;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

/* sv/b64d_decode.sv */
// Message state of the decoder and the single-pass logic that turns one character into results.
`default_nettype none

module b64d_decode #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic [b64d_pkg::CHAR_W-1:0]  char_i,
  input  wire logic                         end_i,
  input  wire logic [b64d_pkg::CAP_W-1:0]   cap_i,
  output b64d_pkg::bundle_t                 bundle_o
);

  localparam int unsigned CW = (COUNT_BITS > b64d_pkg::CAP_W) ? COUNT_BITS : b64d_pkg::CAP_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [b64d_pkg::GROUP_LEN-1:0][b64d_pkg::SEXTET_W-1:0] sx_q, sx_d;
  logic [1:0]            pos_q, pos_d;
  logic [COUNT_BITS-1:0] bw_q, bw_d;
  logic                  stop_q, stop_d;
  logic                  err_q, err_d;
  logic                  pad_q, pad_d;

  logic [b64d_pkg::CODE_W-1:0] code;
  logic                        is_pad, is_bad, end_bad;
  logic [2:0][b64d_pkg::BYTE_W-1:0] dbyte;
  logic [3:0][COUNT_BITS-1:0]  bw_k;
  logic [2:0]                  room, emit;
  logic [1:0]                  want, ne;

  always_comb begin
    code   = b64d_pkg::char_code(char_i);
    is_pad = (code == b64d_pkg::PAD_CODE);
    is_bad = (code == b64d_pkg::BAD_CODE);

    dbyte[0] = {sx_q[0], sx_q[1][5:4]};
    dbyte[1] = {sx_q[1][3:0], sx_q[2][5:2]};
    dbyte[2] = {sx_q[2][1:0], code[5:0]};

    for (int k = 0; k < 4; k++) begin
      bw_k[k] = bw_q + COUNT_BITS'(k);
    end
    // A byte fits while the running count is below both the capacity and the counter limit.
    room[0] = (CW'(bw_k[0]) < CW'(cap_i)) && (bw_k[0] != CNT_MAX);
    room[1] = room[0] && (CW'(bw_k[1]) < CW'(cap_i)) && (bw_k[1] != CNT_MAX);
    room[2] = room[1] && (CW'(bw_k[2]) < CW'(cap_i)) && (bw_k[2] != CNT_MAX);

    sx_d   = sx_q;
    pos_d  = pos_q;
    bw_d   = bw_q;
    stop_d = stop_q;
    err_d  = err_q;
    pad_d  = pad_q;
    want   = 2'd0;
    emit   = 3'b000;
    ne     = 2'd0;

    if (!stop_q) begin
      if (is_bad) begin
        err_d  = 1'b1;
        stop_d = 1'b1;
      end else begin
        case (pos_q)
          2'd0, 2'd1: begin
            if (is_pad) begin
              err_d  = 1'b1;
              stop_d = 1'b1;
            end else begin
              sx_d[pos_q] = code[5:0];
              pos_d       = pos_q + 2'd1;
            end
          end
          2'd2: begin
            pad_d   = is_pad;
            sx_d[2] = is_pad ? '0 : code[5:0];
            pos_d   = 2'd3;
          end
          default: begin
            if (pad_q && !is_pad) begin
              err_d  = 1'b1;
              stop_d = 1'b1;
            end else begin
              want   = pad_q ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
              emit   = room & {(want > 2'd2), (want > 2'd1), 1'b1};
              ne     = 2'(emit[0]) + 2'(emit[1]) + 2'(emit[2]);
              stop_d = pad_q || is_pad || (ne != want);
              bw_d   = bw_q + COUNT_BITS'(ne);
              pos_d  = 2'd0;
              pad_d  = 1'b0;
            end
          end
        endcase
      end
    end

    for (int k = 0; k < b64d_pkg::MAX_RES; k++) begin
      bundle_o.entry[k].out_byte = (k < 3) ? dbyte[k % 3] : '0;
      bundle_o.entry[k].kind     = b64d_pkg::KIND_DATA;
      bundle_o.entry[k].total    = b64d_pkg::TOTAL_W'(bw_k[(k + 1) % 4]);
      bundle_o.entry[k].last     = 1'b0;
    end
    bundle_o.count = b64d_pkg::RES_CNT_W'(ne);

    end_bad = err_d || (!stop_d && (pos_d != 2'd0));
    if (end_i) begin
      bundle_o.entry[ne].out_byte = '0;
      bundle_o.entry[ne].kind     = end_bad ? b64d_pkg::KIND_ERR : b64d_pkg::KIND_OK;
      bundle_o.entry[ne].total    = b64d_pkg::TOTAL_W'(bw_d);
      bundle_o.entry[ne].last     = 1'b1;
      bundle_o.count              = b64d_pkg::RES_CNT_W'(ne) + 3'd1;
      sx_d   = '0;
      pos_d  = 2'd0;
      bw_d   = '0;
      stop_d = 1'b0;
      err_d  = 1'b0;
      pad_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q   <= '0;
      pos_q  <= 2'd0;
      bw_q   <= '0;
      stop_q <= 1'b0;
      err_q  <= 1'b0;
      pad_q  <= 1'b0;
    end else if (accept_i) begin
      sx_q   <= sx_d;
      pos_q  <= pos_d;
      bw_q   <= bw_d;
      stop_q <= stop_d;
      err_q  <= err_d;
      pad_q  <= pad_d;
    end
  end

  // Padding in the third slot only ever leaves the group waiting on its fourth slot.
  a_pad_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_q |-> (pos_q == 2'd3))
    else $error("pad flag set outside the fourth slot");

  // An end-of-message character leaves the message state cleared.
  a_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_i) |=> (bw_q == '0 && pos_q == 2'd0 && !stop_q && !err_q))
    else $error("message state not cleared after end of input");

  // An error always stops decoding.
  a_err_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> stop_q)
    else $error("error seen without decoding stopped");

endmodule

`default_nettype wire

/* sv/b64d_out.sv */
// Result register with one character's results, sent one per cycle while tready_i is high.
`default_nettype none

module b64d_out (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire b64d_pkg::bundle_t bundle_i,
  input  wire logic        tready_i,
  output logic             tvalid_o,
  output b64d_pkg::result_t result_o,
  output logic             ready_o
);

  b64d_pkg::result_t [b64d_pkg::MAX_RES-1:0] ent_q, ent_d;
  logic [b64d_pkg::RES_CNT_W-1:0]            cnt_q, cnt_d;
  logic                                      take;

  always_comb begin
    take     = (cnt_q != '0) && tready_i;
    tvalid_o = (cnt_q != '0);
    result_o = ent_q[0];
    ready_o  = (cnt_q == '0) || ((cnt_q == 3'd1) && tready_i);

    ent_d = ent_q;
    cnt_d = cnt_q;
    if (load_i) begin
      ent_d = bundle_i.entry;
      cnt_d = bundle_i.count;
    end else if (take) begin
      for (int k = 0; k < b64d_pkg::MAX_RES - 1; k++) begin
        ent_d[k] = ent_q[k + 1];
      end
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(b64d_pkg::MAX_RES))
    else $error("result count out of range");

  // A new set of results is only loaded once the previous one is drained.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ((cnt_q == '0) || (cnt_q == 3'd1 && take)))
    else $error("results loaded over undelivered results");

  // Only the final result of a set may close a message.
  a_last_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tvalid_o && result_o.last) |-> (cnt_q == 3'd1))
    else $error("closing result is not the last of its set");

endmodule

`default_nettype wire

/* sv/base64_decoder_core.sv */
// Top level of the streaming base64 decoder with its configuration register.
//
// Usage: base64 text enters on the s_axis channel, one character per transaction, with
// s_axis_tlast marking the final character of a message. Decoded bytes leave on m_axis,
// one per transaction, with tuser = data; after the final character one closing transaction
// carries tlast = 1, tuser = success or error and the message byte total in the upper data
// bits. The APB port holds output_capacity, the most data bytes sent per message.
// The results of a character are registered and appear in the cycle after its transaction.
// Throughput: one character per cycle while each character yields at most one result and
// the receiver is ready. A character that completes a group yields up to three bytes (four
// with a closing result), handed out one per cycle while the receiver is ready; the input
// waits meanwhile. Sustained rate is set by the single output port of the result register.
// The next character is taken in the same cycle as the last pending result leaves.
// Reset clears the message state, empties the result register and sets output_capacity to
// 65535; no clearing pass is needed. When the receiver stalls, the pending result holds
// steady and the input is held off once the buffered results are not drained.
`default_nettype none

module base64_decoder_core #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  wire logic        s_axis_tlast,   // end_of_input
  // Output stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] out_byte, [23:8] total_bytes
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast,   // last
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [b64d_pkg::CAP_W-1:0] cap_q;
  logic                       in_acc;
  logic                       cfg_wr;
  b64d_pkg::bundle_t          bundle;
  b64d_pkg::result_t          result;

  // A transaction on the input stream both advances the state and loads the result register.
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Register index is the word address; the byte offset bits are not decoded.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == b64d_pkg::REG_OUTPUT_CAPACITY);
  assign prdata = (paddr[2] == b64d_pkg::REG_OUTPUT_CAPACITY) ?
                  {16'd0, cap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= b64d_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[15:0];
    end
  end

  b64d_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .char_i   (s_axis_tdata),
    .end_i    (s_axis_tlast),
    .cap_i    (cap_q),
    .bundle_o (bundle)
  );

  b64d_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_acc),
    .bundle_i (bundle),
    .tready_i (m_axis_tready),
    .tvalid_o (m_axis_tvalid),
    .result_o (result),
    .ready_o  (s_axis_tready)
  );

  assign m_axis_tdata = {result.total, result.out_byte};
  assign m_axis_tuser = result.kind;
  assign m_axis_tlast = result.last;

endmodule

`default_nettype wire

/* bench/tb_base64_decoder_core.sv */
// Self-checking testbench for the streaming base64 decoder core.
`timescale 1ns / 100ps

module tb_base64_decoder_core;

  // The run is cut off here.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Items accepted by the decoder in the random part, spread evenly over the capacity phases.
  localparam int unsigned RANDOM_ITEMS = 384;
  localparam int unsigned PHASE_COUNT = 8;
  // The capacity register sits at byte address four times its index.
  localparam logic [2:0] CAP_ADDR = {b64d_pkg::REG_OUTPUT_CAPACITY, 2'b00};

  // One row of directed stimulus. Closing rows may pin the end transaction to a
  // value typed in by hand; all other rows are checked against the predictor.
  typedef struct packed {
    logic [7:0]      chr;
    logic            eoi;
    logic            pinned;
    b64d_pkg::kind_e kind;
    logic [15:0]     total;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  base64_decoder_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Shadow of the decoder state, advanced once per accepted input transaction.
  logic [5:0]  sextets [3];
  logic [1:0]  group_slot;
  logic [15:0] bytes_out;
  logic        halted;
  logic        bad_seen;
  logic        pad_in_third;
  logic [15:0] capacity;

  b64d_pkg::result_t decoded_q [$];   // Output transactions still to arrive, oldest first.
  stim_row_t   offered_q [$];   // Rows offered on the input, waiting for acceptance.
  logic [7:0]  msg_q [$];       // Characters of the message being built.

  int unsigned mismatches = 0;
  int unsigned sent_items = 0;  // Input transactions accepted so far.
  int unsigned cycles = 0;
  int unsigned hold_len = 0;    // Long receiver hold-off requested by the sequencer.
  bit          no_gaps = 1'b0;  // Forces the sender to offer back to back.
  int unsigned send_run_left = 0;
  bit          send_run_gappy = 1'b0;

  // Directed part: alphabet extremes in two full groups, both padding forms, a
  // character above the ASCII range, a NUL, misplaced padding in the first slot,
  // a partial trailing group and a data character after padding in the third slot.
  stim_row_t directed_rows [0:25] = '{
    '{"A", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"Z", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"a", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"z", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"0", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"9", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"+", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"/", 1'b1, 1'b1, b64d_pkg::KIND_OK,   16'd6},
    '{"Q", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"Q", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"=", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"=", 1'b1, 1'b1, b64d_pkg::KIND_OK,   16'd1},
    '{"Q", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"U", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"I", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"=", 1'b1, 1'b1, b64d_pkg::KIND_OK,   16'd2},
    '{8'hFF, 1'b1, 1'b1, b64d_pkg::KIND_ERR, 16'd0},
    '{8'h00, 1'b1, 1'b1, b64d_pkg::KIND_ERR, 16'd0},
    '{"=", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"Q", 1'b1, 1'b1, b64d_pkg::KIND_ERR,  16'd0},
    '{"Q", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"U", 1'b1, 1'b1, b64d_pkg::KIND_ERR,  16'd0},
    '{"Q", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"Q", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"=", 1'b0, 1'b0, b64d_pkg::KIND_DATA, 16'd0},
    '{"A", 1'b1, 1'b1, b64d_pkg::KIND_ERR,  16'd0}
  };

  // Sextet value of a character, the pad code for the pad character, else the bad code.
  function automatic logic [6:0] sextet_code(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (b64_alphabet[i] == c) return 7'(i);
    end
    if (c == "=") return b64d_pkg::PAD_CODE;
    return b64d_pkg::BAD_CODE;
  endfunction

  // Wait length for one transaction. Each run of items is drawn at random to either
  // wait a random length before every item or not wait at all.
  function automatic int unsigned draw_wait(inout int unsigned run_left, inout bit gappy);
    if (run_left == 0) begin
      run_left = $urandom_range(1, 30);
      gappy = 1'($urandom_range(0, 1));
    end
    run_left--;
    return gappy ? $urandom_range(0, 18) : 0;
  endfunction

  function automatic void clear_message_state();
    sextets[0] = '0;
    sextets[1] = '0;
    sextets[2] = '0;
    group_slot = '0;
    bytes_out = '0;
    halted = 1'b0;
    bad_seen = 1'b0;
    pad_in_third = 1'b0;
  endfunction

  // Queues one decoded byte, unless decoding has stopped or the capacity is used up;
  // reaching the capacity stops decoding without marking an error.
  function automatic void queue_byte(input logic [7:0] b);
    b64d_pkg::result_t r;
    if (!halted) begin
      if (bytes_out >= capacity || bytes_out == 16'hFFFF) begin
        halted = 1'b1;
      end else begin
        bytes_out++;
        r.out_byte = b;
        r.kind = b64d_pkg::KIND_DATA;
        r.total = bytes_out;
        r.last = 1'b0;
        decoded_q.push_back(r);
      end
    end
  endfunction

  // Advances the shadow state by one character and queues what it yields.
  function automatic void decode_char(input logic [7:0] c, input logic eoi);
    logic [6:0] code;
    b64d_pkg::result_t r;
    code = sextet_code(c);
    if (!halted) begin
      if (code == b64d_pkg::BAD_CODE) begin
        bad_seen = 1'b1;
        halted = 1'b1;
      end else if (group_slot < 2) begin
        // Padding is never allowed in the first two slots of a group.
        if (code == b64d_pkg::PAD_CODE) begin
          bad_seen = 1'b1;
          halted = 1'b1;
        end else begin
          sextets[group_slot] = code[5:0];
          group_slot++;
        end
      end else if (group_slot == 2) begin
        pad_in_third = (code == b64d_pkg::PAD_CODE);
        sextets[2] = pad_in_third ? 6'd0 : code[5:0];
        group_slot = 2'd3;
      end else if (pad_in_third && code != b64d_pkg::PAD_CODE) begin
        bad_seen = 1'b1;
        halted = 1'b1;
      end else begin
        queue_byte({sextets[0], sextets[1][5:4]});
        if (pad_in_third) begin
          halted = 1'b1;
        end else begin
          queue_byte({sextets[1][3:0], sextets[2][5:2]});
          if (code == b64d_pkg::PAD_CODE) halted = 1'b1;
          else queue_byte({sextets[2][1:0], code[5:0]});
        end
        group_slot = '0;
        pad_in_third = 1'b0;
      end
    end
    if (eoi) begin
      // An unfinished group counts as an error only while decoding still runs.
      r.out_byte = '0;
      r.kind = (bad_seen || (!halted && group_slot != 0)) ?
               b64d_pkg::KIND_ERR : b64d_pkg::KIND_OK;
      r.total = bytes_out;
      r.last = 1'b1;
      decoded_q.push_back(r);
      clear_message_state();
    end
  endfunction

  // Offers one character and returns at the clock edge of its transaction.
  task automatic offer_char(input stim_row_t row);
    int unsigned gap;
    gap = no_gaps ? 0 : draw_wait(send_run_left, send_run_gappy);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    offered_q.push_back(row);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= row.chr;
    s_axis_tlast <= row.eoi;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_message();
    stim_row_t row;
    foreach (msg_q[i]) begin
      row = '0;
      row.chr = msg_q[i];
      row.eoi = (i == msg_q.size() - 1);
      offer_char(row);
    end
  endtask

  // Builds a message: mostly well-formed groups with random content and an
  // optional padded tail, sometimes damaged, cut short or followed by junk,
  // and now and then pure byte noise.
  task automatic build_message(input bit clean);
    int unsigned groups;
    int unsigned count;
    msg_q.delete();
    if (!clean && $urandom_range(0, 3) == 0) begin
      count = $urandom_range(1, 6);
      repeat (count) msg_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      groups = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      repeat (4 * groups) msg_q.push_back(b64_alphabet[$urandom_range(0, 63)]);
      case ($urandom_range(0, 2))
        1: begin
          repeat (2) msg_q.push_back(b64_alphabet[$urandom_range(0, 63)]);
          repeat (2) msg_q.push_back("=");
        end
        2: begin
          repeat (3) msg_q.push_back(b64_alphabet[$urandom_range(0, 63)]);
          msg_q.push_back("=");
        end
        default: ;
      endcase
      if (msg_q.size() == 0) begin
        repeat (4) msg_q.push_back(b64_alphabet[$urandom_range(0, 63)]);
      end
      if (!clean) begin
        case ($urandom_range(0, 9))
          0: msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
          1: msg_q[$urandom_range(0, msg_q.size() - 1)] = "=";
          2: begin
            count = $urandom_range(1, 3);
            while (count > 0 && msg_q.size() > 1) begin
              void'(msg_q.pop_back());
              count--;
            end
          end
          3: begin
            count = $urandom_range(1, 3);
            repeat (count) msg_q.push_back(8'($urandom_range(0, 255)));
          end
          default: ;
        endcase
      end
    end
  endtask

  // Stops offering and waits until every expected output transaction has been
  // seen, then lets the result register settle. The first edge is always
  // waited for, so that the last item's prediction is queued.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (decoded_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Optionally writes output_capacity, then reads it back. The read setup follows
  // the write access directly, so psel stays high and no signal is driven twice
  // in one time step.
  task automatic access_capacity(input bit do_write, input logic [31:0] data);
    if (do_write) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CAP_ADDR;
      pwdata <= data;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      capacity = data[15:0];
    end
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CAP_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {16'd0, capacity}) begin
      $error("output_capacity expected %0h actual %0h", {16'd0, capacity}, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: waits a random number of cycles before each output transaction,
  // or holds off for a long stretch when the sequencer asks for it.
  initial begin : receiver
    int unsigned stall;
    int unsigned recv_run_left;
    bit          recv_run_gappy;
    recv_run_left = 0;
    recv_run_gappy = 1'b0;
    forever begin
      if (hold_len != 0) begin
        stall = hold_len;
        hold_len = 0;
      end else begin
        stall = draw_wait(recv_run_left, recv_run_gappy);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Observer: checks each output transaction against the oldest expectation, then
  // feeds the accepted input transaction of the same edge to the predictor. All
  // values are sampled at the clock edge, before any of this edge's updates land.
  always @(posedge clk_i) begin : observer
    b64d_pkg::result_t want;
    stim_row_t row;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected output transaction: byte %0h kind %0d total %0d last %0b",
                 m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[23:8], m_axis_tlast);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tdata[7:0] !== want.out_byte) begin
            $error("out_byte expected %0h actual %0h", want.out_byte, m_axis_tdata[7:0]);
            mismatches++;
          end
          if (m_axis_tuser !== want.kind) begin
            $error("kind expected %0d actual %0d", want.kind, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tdata[23:8] !== want.total) begin
            $error("total_bytes expected %0d actual %0d", want.total, m_axis_tdata[23:8]);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last expected %0b actual %0b", want.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        row = offered_q.pop_front();
        sent_items++;
        decode_char(s_axis_tdata, s_axis_tlast);
        // A pinned row replaces the predicted end transaction by its typed value.
        if (row.pinned) begin
          want = decoded_q.pop_back();
          want.kind = row.kind;
          want.total = row.total;
          decoded_q.push_back(want);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_base64_decoder_core failed");
      $finish;
    end
  end

  // Sequencer: reset, directed rows at the reset capacity, then random phases,
  // each behind a capacity write made while the decoder is idle.
  initial begin : sequencer
    logic [15:0] phase_caps [PHASE_COUNT];
    int unsigned phase_goal;
    int unsigned flood_start;
    clear_message_state();
    capacity = b64d_pkg::CAP_RESET;
    phase_caps = '{16'd0, 16'd1, 16'd2, 16'd3, 16'hFFFF,
                   16'($urandom_range(4, 20)), 16'($urandom_range(0, 65535)), 16'hFFFF};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    access_capacity(1'b0, 32'd0);

    foreach (directed_rows[i]) offer_char(directed_rows[i]);
    drain();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      access_capacity(1'b1, {16'($urandom), phase_caps[p]});
      if (phase_caps[p] == 16'hFFFF && p == 4) begin
        // Hold the receiver off for a long time while well-formed text streams in
        // back to back, so the result register fills and the input is stalled.
        hold_len = 300;
        no_gaps = 1'b1;
        flood_start = sent_items;
        while (sent_items < flood_start + 40) begin
          build_message(1'b1);
          send_message();
        end
        no_gaps = 1'b0;
      end
      phase_goal = sent_items + RANDOM_ITEMS / PHASE_COUNT;
      while (sent_items < phase_goal) begin
        build_message(1'b0);
        send_message();
        // Now and then the sender pauses until every expected result is out.
        if ($urandom_range(0, 7) == 0) drain();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("tb_base64_decoder_core passed");
    end else begin
      $display("tb_base64_decoder_core failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/b64d_pkg.sv
sv/b64d_decode.sv
sv/b64d_out.sv
sv/base64_decoder_core.sv
bench/tb_base64_decoder_core.sv
